// ----- hw/rtl/urfl_pkg.sv -----
// Shared types, constants and helpers for the UART register file with loopback.
// Used by urfl_rx_fifo and uart_register_file_loopback_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urfl_pkg;

  // Receive FIFO geometry
  localparam int RX_DEPTH = 64;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_FW    = $clog2(RX_DEPTH + 1);

  // Bus status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SIZE   = 3'd1;
  localparam logic [2:0] ST_UNIMPL = 3'd2;
  localparam logic [2:0] ST_RO     = 3'd3;
  localparam logic [2:0] ST_UNDEF  = 3'd4;
  localparam logic [2:0] ST_SLEEP  = 3'd5;

  // Access opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register bank selected by LCR
  localparam logic [1:0] BANK_OP = 2'd0;
  localparam logic [1:0] BANK_A  = 2'd1;
  localparam logic [1:0] BANK_B  = 2'd2;

  // Register indexes (byte offset / 4)
  localparam logic [4:0] REG_RHR    = 5'd0;
  localparam logic [4:0] REG_IER    = 5'd1;
  localparam logic [4:0] REG_IIR    = 5'd2;
  localparam logic [4:0] REG_LCR    = 5'd3;
  localparam logic [4:0] REG_MCR    = 5'd4;
  localparam logic [4:0] REG_LSR    = 5'd5;
  localparam logic [4:0] REG_MSR    = 5'd6;
  localparam logic [4:0] REG_SPR    = 5'd7;
  localparam logic [4:0] REG_MDR1   = 5'd8;
  localparam logic [4:0] REG_MDR2   = 5'd9;
  localparam logic [4:0] REG_SFLSR  = 5'd10;
  localparam logic [4:0] REG_RESUME = 5'd11;
  localparam logic [4:0] REG_SFREGL = 5'd12;
  localparam logic [4:0] REG_SFREGH = 5'd13;
  localparam logic [4:0] REG_UASR   = 5'd14;
  localparam logic [4:0] REG_SCR    = 5'd16;
  localparam logic [4:0] REG_SSR    = 5'd17;
  localparam logic [4:0] REG_MVR    = 5'd20;
  localparam logic [4:0] REG_SYSC   = 5'd21;
  localparam logic [4:0] REG_SYSS   = 5'd22;
  localparam logic [4:0] REG_WER    = 5'd23;

  // Reset values, the loopback MSR pattern and the config-B LCR key
  localparam logic [7:0] LSR_RST  = 8'h60;
  localparam logic [7:0] IIR_RST  = 8'h01;
  localparam logic [7:0] MDR1_RST = 8'h07;
  localparam logic [7:0] MSR_LOOP = 8'h96;
  localparam logic [7:0] LCR_CFGB = 8'hBF;

  // Input beat
  typedef struct packed {
    logic       opcode;
    logic [4:0] reg_index;
    logic [7:0] write_data;
    logic       access_is_byte;
  } uart_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] status;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } uart_out_t;

  // FIFO control from the register decoder
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } rx_ctl_t;

  // FIFO status back to the register decoder; last means one entry left
  typedef struct packed {
    logic [7:0] hold;
    logic       empty;
    logic       full;
    logic       last;
  } rx_sts_t;

  // Ring pointer increment with wrap at RX_DEPTH
  function automatic logic [RX_AW-1:0] ptr_inc(input logic [RX_AW-1:0] p);
    if (p == RX_AW'(RX_DEPTH - 1)) begin
      return '0;
    end
    return p + RX_AW'(1);
  endfunction

  // Bank decode from the line control register
  function automatic logic [1:0] bank_of(input logic [7:0] lcr);
    if (!lcr[7]) begin
      return BANK_OP;
    end else if ((lcr & LCR_CFGB) == LCR_CFGB) begin
      return BANK_B;
    end
    return BANK_A;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/urfl_rx_fifo.sv -----
// Receive FIFO for the loopback path: ring memory, head/tail/fill, RHR holding byte.
// Depends on urfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urfl_rx_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire urfl_pkg::rx_ctl_t ctl,
  input  wire logic [7:0]       push_byte,
  output urfl_pkg::rx_sts_t     sts
);
  import urfl_pkg::*;

  logic [7:0]       mem [RX_DEPTH];
  logic [RX_AW-1:0] head_r, head_nxt;
  logic [RX_AW-1:0] tail_r, tail_nxt;
  logic [RX_FW-1:0] fill_r, fill_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [7:0]       pf_r;
  logic [RX_AW-1:0] pf_addr;
  logic             full;
  logic             empty;
  logic             wr_en;

  assign full  = (fill_r == RX_FW'(RX_DEPTH));
  assign empty = (fill_r == '0);
  assign wr_en = ctl.push && !ctl.clear && !full;

  // Pointer and holding byte update; pf_r holds the entry after the head
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    hold_nxt = hold_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
      hold_nxt = '0;
    end else if (wr_en) begin
      tail_nxt = ptr_inc(tail_r);
      fill_nxt = fill_r + RX_FW'(1);
      if (empty) begin
        hold_nxt = push_byte;
      end
    end else if (ctl.pop && !empty) begin
      head_nxt = ptr_inc(head_r);
      fill_nxt = fill_r - RX_FW'(1);
      hold_nxt = (fill_r == RX_FW'(1)) ? 8'h00 : pf_r;
    end
  end

  assign pf_addr = ptr_inc(head_nxt);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      hold_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      hold_r <= hold_nxt;
    end
  end

  // Ring memory with registered prefetch read, bypassed on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= push_byte;
    end
    if (wr_en && (tail_r == pf_addr)) begin
      pf_r <= push_byte;
    end else begin
      pf_r <= mem[pf_addr];
    end
  end

  assign sts.hold  = hold_r;
  assign sts.empty = empty;
  assign sts.full  = full;
  assign sts.last  = (fill_r == RX_FW'(1));

endmodule

`default_nettype wire

// ----- hw/rtl/uart_register_file_loopback_core.sv -----
// UART 16550-style register file with internal loopback FIFO.
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one access per cycle; the RX ring memory has one write and one prefetch read.
// in_ready stays high while the result register is empty or being drained.
// Reset (rst_n, synchronous) restores register file and FIFO; ring memory needs no clearing.
// A SYSC write with bit 1 set performs the same reset, then loads SYSC. Depends on urfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uart_register_file_loopback_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire urfl_pkg::uart_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output urfl_pkg::uart_out_t      out_data
);
  import urfl_pkg::*;

  logic in_fire;

  // Register file
  logic [7:0] lsr_r,  lsr_nxt;
  logic [7:0] dll_r,  dll_nxt;
  logic [7:0] dlh_r,  dlh_nxt;
  logic [7:0] ier_r,  ier_nxt;
  logic [7:0] iir_r,  iir_nxt;
  logic [7:0] fcr_r,  fcr_nxt;
  logic [7:0] efr_r,  efr_nxt;
  logic [7:0] lcr_r,  lcr_nxt;
  logic [7:0] mcr_r,  mcr_nxt;
  logic [7:0] msr_r,  msr_nxt;
  logic [7:0] spr_r,  spr_nxt;
  logic [7:0] icr_r,  icr_nxt;
  logic [7:0] mdr1_r, mdr1_nxt;
  logic [7:0] scr_r,  scr_nxt;
  logic [7:0] sysc_r, sysc_nxt;
  logic       loop_r, loop_nxt;

  // Result register
  logic      out_valid_r;
  uart_out_t out_data_r;
  uart_out_t res;

  rx_ctl_t rx_ctl;
  rx_sts_t rx_sts;

  logic [1:0] bank;
  logic       msr_spr;
  logic [7:0] wd;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign bank     = bank_of(lcr_r);
  assign msr_spr  = !efr_r[4] || !mcr_r[6];
  assign wd       = in_data.write_data;

  // Access decode and next register values
  always_comb begin
    lsr_nxt  = lsr_r;
    dll_nxt  = dll_r;
    dlh_nxt  = dlh_r;
    ier_nxt  = ier_r;
    iir_nxt  = iir_r;
    fcr_nxt  = fcr_r;
    efr_nxt  = efr_r;
    lcr_nxt  = lcr_r;
    mcr_nxt  = mcr_r;
    msr_nxt  = msr_r;
    spr_nxt  = spr_r;
    icr_nxt  = icr_r;
    mdr1_nxt = mdr1_r;
    scr_nxt  = scr_r;
    sysc_nxt = sysc_r;
    loop_nxt = loop_r;
    rx_ctl   = '0;
    res      = '0;
    res.status = ST_OK;

    if (!in_data.access_is_byte) begin
      res.status = ST_SIZE;
    end else if (in_data.opcode == OP_READ) begin
      unique case (in_data.reg_index) inside
        REG_RHR: begin
          if (bank != BANK_OP) begin
            res.read_data = dll_r;
          end else if (lsr_r[0] && !rx_sts.empty) begin
            // pop: the FIFO reloads the holding byte from the next entry, or clears it on the last
            res.read_data = rx_sts.hold;
            rx_ctl.pop    = 1'b1;
            lsr_nxt[1]    = 1'b0;
            if (rx_sts.last) begin
              lsr_nxt[0] = 1'b0;
            end
          end
        end
        REG_IER: res.read_data = (bank == BANK_OP) ? ier_r : dlh_r;
        REG_IIR: res.read_data = (bank == BANK_B) ? efr_r : iir_r;
        REG_LCR: res.read_data = lcr_r;
        REG_MCR: begin
          if (bank == BANK_B) res.status = ST_UNIMPL;
          else                res.read_data = mcr_r;
        end
        REG_LSR: begin
          if (bank == BANK_B) res.status = ST_UNIMPL;
          else                res.read_data = lsr_r;
        end
        REG_MSR: begin
          if (bank == BANK_B || !msr_spr) res.status = ST_UNIMPL;
          else                            res.read_data = msr_r;
        end
        REG_SPR: begin
          if (bank == BANK_B || !msr_spr) res.status = ST_UNIMPL;
          else                            res.read_data = spr_r;
        end
        REG_MDR1: res.read_data = mdr1_r;
        REG_MDR2, REG_SFLSR, REG_RESUME, REG_SFREGL, REG_SFREGH, REG_UASR,
        REG_SCR, REG_SSR, REG_MVR, REG_SYSC, REG_SYSS, REG_WER:
          res.status = ST_UNIMPL;
        default: res.status = ST_UNDEF;
      endcase
    end else begin
      unique case (in_data.reg_index) inside
        REG_RHR: begin
          if (bank != BANK_OP) begin
            if (ier_r[4]) res.status = ST_SLEEP;
            else          dll_nxt = wd;
          end else if (loop_r) begin
            if (rx_sts.full) begin
              lsr_nxt[1] = 1'b1;
            end else begin
              rx_ctl.push = 1'b1;
              lsr_nxt[0]  = 1'b1;
            end
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = wd;
          end
        end
        REG_IER: begin
          if (bank != BANK_OP) begin
            if (ier_r[4]) res.status = ST_SLEEP;
            else          dlh_nxt = wd;
          end else if (!efr_r[4]) begin
            ier_nxt = {ier_r[7:4], wd[3:0]};
          end else begin
            ier_nxt = wd;
          end
        end
        REG_IIR: begin
          if (bank == BANK_B) begin
            efr_nxt = wd;
          end else begin
            if (wd[1]) begin
              rx_ctl.clear = 1'b1;
              lsr_nxt[4:0] = 5'b0;
            end
            fcr_nxt = wd;
            iir_nxt = {{2{wd[0]}}, iir_r[5:0]};
          end
        end
        REG_LCR: lcr_nxt = wd;
        REG_MCR: begin
          if (bank == BANK_B) begin
            res.status = ST_UNIMPL;
          end else begin
            // loopback enable edge forces the modem status pattern
            if (wd[4] && !mcr_r[4]) begin
              loop_nxt = 1'b1;
              msr_nxt  = MSR_LOOP;
            end else if (mcr_r[4] && !wd[4]) begin
              loop_nxt = 1'b0;
            end
            if (!efr_r[4]) mcr_nxt = {mcr_r[7:5], wd[4:0]};
            else           mcr_nxt = {mcr_r[7:6], wd[5:0]};
          end
        end
        REG_LSR: begin
          if (bank == BANK_B) res.status = ST_UNIMPL;
          else                icr_nxt = wd;
        end
        REG_MSR: res.status = ST_UNIMPL;
        REG_SPR: begin
          if (bank == BANK_B || !msr_spr) res.status = ST_UNIMPL;
          else                            spr_nxt = wd;
        end
        REG_MDR1: mdr1_nxt = wd;
        REG_SCR:  scr_nxt  = wd;
        REG_SYSC: begin
          if (wd[1]) begin
            // soft reset of the register file apart from SYSC, plus a FIFO clear
            lsr_nxt  = LSR_RST;
            dll_nxt  = '0;
            dlh_nxt  = '0;
            ier_nxt  = '0;
            iir_nxt  = IIR_RST;
            fcr_nxt  = '0;
            efr_nxt  = '0;
            lcr_nxt  = '0;
            mcr_nxt  = '0;
            msr_nxt  = '0;
            spr_nxt  = '0;
            icr_nxt  = '0;
            mdr1_nxt = MDR1_RST;
            scr_nxt  = '0;
            loop_nxt = 1'b0;
            rx_ctl.clear = 1'b1;
          end
          sysc_nxt = wd;
        end
        REG_UASR, REG_SSR, REG_MVR, REG_SYSS: res.status = ST_RO;
        REG_MDR2, REG_SFLSR, REG_RESUME, REG_SFREGL, REG_SFREGH, REG_WER:
          res.status = ST_UNIMPL;
        default: res.status = ST_UNDEF;
      endcase
    end
  end

  // Register file update on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsr_r  <= LSR_RST;
      dll_r  <= '0;
      dlh_r  <= '0;
      ier_r  <= '0;
      iir_r  <= IIR_RST;
      fcr_r  <= '0;
      efr_r  <= '0;
      lcr_r  <= '0;
      mcr_r  <= '0;
      msr_r  <= '0;
      spr_r  <= '0;
      icr_r  <= '0;
      mdr1_r <= MDR1_RST;
      scr_r  <= '0;
      sysc_r <= '0;
      loop_r <= 1'b0;
    end else if (in_fire) begin
      lsr_r  <= lsr_nxt;
      dll_r  <= dll_nxt;
      dlh_r  <= dlh_nxt;
      ier_r  <= ier_nxt;
      iir_r  <= iir_nxt;
      fcr_r  <= fcr_nxt;
      efr_r  <= efr_nxt;
      lcr_r  <= lcr_nxt;
      mcr_r  <= mcr_nxt;
      msr_r  <= msr_nxt;
      spr_r  <= spr_nxt;
      icr_r  <= icr_nxt;
      mdr1_r <= mdr1_nxt;
      scr_r  <= scr_nxt;
      sysc_r <= sysc_nxt;
      loop_r <= loop_nxt;
    end
  end

  // Result register: refilled on accept, drained on out_ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // FIFO commands only take effect on an accepted beat
  rx_ctl_t rx_ctl_gated;
  assign rx_ctl_gated.push  = rx_ctl.push  && in_fire;
  assign rx_ctl_gated.pop   = rx_ctl.pop   && in_fire;
  assign rx_ctl_gated.clear = rx_ctl.clear && in_fire;

  urfl_rx_fifo u_rx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rx_ctl_gated),
    .push_byte (wd),
    .sts       (rx_sts)
  );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for uart_register_file_loopback_core: directed and random register
// accesses, checked beat by beat against a scoreboard that tracks the register file state.
// Depends on urfl_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import urfl_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;

  // Register file state mirror and expected-result store
  class uart_reg_scoreboard;
    uart_out_t   expected_results[$];
    int unsigned fail_count;
    int unsigned checked;
    int unsigned overruns;
    int unsigned tx_sent;
    int unsigned soft_resets;
    int unsigned status_seen[8];

    logic [7:0] rx_ring [RX_DEPTH];
    int         rx_head;
    int         rx_fill;
    logic [7:0] hold, lsr, dll, dlh, ier, iir, fcr, efr, lcr, mcr, msr, spr;
    logic [7:0] icr, mdr1, scr, sysc;
    bit         loop_on;

    function new();
      reset_state();
    endfunction

    function void reset_state();
      rx_head = 0;
      rx_fill = 0;
      hold = 8'h00;
      lsr = 8'h60;
      dll = 8'h00;
      dlh = 8'h00;
      ier = 8'h00;
      iir = 8'h01;
      fcr = 8'h00;
      efr = 8'h00;
      lcr = 8'h00;
      mcr = 8'h00;
      msr = 8'h00;
      spr = 8'h00;
      icr = 8'h00;
      mdr1 = 8'h07;
      scr = 8'h00;
      sysc = 8'h00;
      loop_on = 1'b0;
    endfunction

    function logic [1:0] bank_sel();
      if (!lcr[7]) begin
        return BANK_OP;
      end
      if ((lcr | 8'h40) == 8'hFF) begin
        return BANK_B;
      end
      return BANK_A;
    endfunction

    // MSR/SPR are hidden while the TCR/TLR pair is mapped in
    function bit msr_spr_visible();
      return !efr[4] || !mcr[6];
    endfunction

    function logic [2:0] read_reg(input logic [4:0] idx, output logic [7:0] rd);
      logic [1:0] bk;
      bk = bank_sel();
      rd = 8'h00;
      case (idx)
        REG_RHR: begin
          if (bk != BANK_OP) begin
            rd = dll;
          end else if (lsr[0] && rx_fill != 0) begin
            rd = hold;
            rx_head = (rx_head + 1) % RX_DEPTH;
            rx_fill--;
            lsr[1] = 1'b0;
            if (rx_fill == 0) begin
              hold = 8'h00;
              lsr[0] = 1'b0;
            end else begin
              hold = rx_ring[rx_head];
            end
          end
          return ST_OK;
        end
        REG_IER: begin
          rd = (bk == BANK_OP) ? ier : dlh;
          return ST_OK;
        end
        REG_IIR: begin
          rd = (bk == BANK_B) ? efr : iir;
          return ST_OK;
        end
        REG_LCR: begin
          rd = lcr;
          return ST_OK;
        end
        REG_MCR: begin
          if (bk == BANK_B) return ST_UNIMPL;
          rd = mcr;
          return ST_OK;
        end
        REG_LSR: begin
          if (bk == BANK_B) return ST_UNIMPL;
          rd = lsr;
          return ST_OK;
        end
        REG_MSR: begin
          if (bk == BANK_B || !msr_spr_visible()) return ST_UNIMPL;
          rd = msr;
          return ST_OK;
        end
        REG_SPR: begin
          if (bk == BANK_B || !msr_spr_visible()) return ST_UNIMPL;
          rd = spr;
          return ST_OK;
        end
        REG_MDR1: begin
          rd = mdr1;
          return ST_OK;
        end
        REG_MDR2, REG_SFLSR, REG_RESUME, REG_SFREGL, REG_SFREGH, REG_UASR,
        REG_SCR, REG_SSR, REG_MVR, REG_SYSC, REG_SYSS, REG_WER:
          return ST_UNIMPL;
        default:
          return ST_UNDEF;
      endcase
    endfunction

    function logic [2:0] write_reg(input logic [4:0] idx, input logic [7:0] v,
                                   output logic txv, output logic [7:0] txb);
      logic [1:0] bk;
      bk = bank_sel();
      txv = 1'b0;
      txb = 8'h00;
      case (idx)
        REG_RHR: begin
          if (bk != BANK_OP) begin
            if (ier[4]) return ST_SLEEP;
            dll = v;
          end else if (loop_on) begin
            if (rx_fill >= RX_DEPTH) begin
              lsr[1] = 1'b1;
              overruns++;
            end else begin
              if (rx_fill == 0) hold = v;
              rx_ring[(rx_head + rx_fill) % RX_DEPTH] = v;
              lsr[0] = 1'b1;
              rx_fill++;
            end
          end else begin
            txv = 1'b1;
            txb = v;
          end
          return ST_OK;
        end
        REG_IER: begin
          if (bk != BANK_OP) begin
            if (ier[4]) return ST_SLEEP;
            dlh = v;
          end else if (efr[4]) begin
            ier = v;
          end else begin
            ier = {ier[7:4], v[3:0]};
          end
          return ST_OK;
        end
        REG_IIR: begin
          if (bk == BANK_B) begin
            efr = v;
            return ST_OK;
          end
          // FIFO clear drops all queued bytes and the receive status bits
          if (v[1]) begin
            rx_head = 0;
            rx_fill = 0;
            hold = 8'h00;
            lsr[4:0] = 5'd0;
          end
          fcr = v;
          iir[7:6] = {2{v[0]}};
          return ST_OK;
        end
        REG_LCR: begin
          lcr = v;
          return ST_OK;
        end
        REG_MCR: begin
          if (bk == BANK_B) return ST_UNIMPL;
          if (v[4] && !mcr[4]) begin
            loop_on = 1'b1;
            msr = 8'h96;
          end else if (mcr[4] && !v[4]) begin
            loop_on = 1'b0;
          end
          if (efr[4]) mcr = {mcr[7:6], v[5:0]};
          else        mcr = {mcr[7:5], v[4:0]};
          return ST_OK;
        end
        REG_LSR: begin
          if (bk == BANK_B) return ST_UNIMPL;
          icr = v;
          return ST_OK;
        end
        REG_MSR:
          return ST_UNIMPL;
        REG_SPR: begin
          if (bk == BANK_B || !msr_spr_visible()) return ST_UNIMPL;
          spr = v;
          return ST_OK;
        end
        REG_MDR1: begin
          mdr1 = v;
          return ST_OK;
        end
        REG_SCR: begin
          scr = v;
          return ST_OK;
        end
        REG_SYSC: begin
          if (v[1]) begin
            reset_state();
            soft_resets++;
          end
          sysc = v;
          return ST_OK;
        end
        REG_UASR, REG_SSR, REG_MVR, REG_SYSS:
          return ST_RO;
        REG_MDR2, REG_SFLSR, REG_RESUME, REG_SFREGL, REG_SFREGH, REG_WER:
          return ST_UNIMPL;
        default:
          return ST_UNDEF;
      endcase
    endfunction

    // One accepted access: update the mirror and queue its result
    function void note_access(input uart_in_t acc);
      uart_out_t  e;
      logic [7:0] rd;
      logic       txv;
      logic [7:0] txb;
      e = '0;
      if (!acc.access_is_byte) begin
        e.status = ST_SIZE;
      end else if (acc.opcode == OP_READ) begin
        e.status = read_reg(acc.reg_index, rd);
        e.read_data = (e.status == ST_OK) ? rd : 8'h00;
      end else begin
        e.status = write_reg(acc.reg_index, acc.write_data, txv, txb);
        e.tx_valid = txv;
        e.tx_byte = txv ? txb : 8'h00;
        if (txv) tx_sent++;
      end
      status_seen[e.status]++;
      expected_results.push_back(e);
    endfunction

    function void check_result(input uart_out_t got);
      uart_out_t e;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: rd=%02h st=%0d txv=%0b txb=%02h",
                   got.read_data, got.status, got.tx_valid, got.tx_byte);
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (got.read_data !== e.read_data || got.status !== e.status ||
          got.tx_valid !== e.tx_valid || got.tx_byte !== e.tx_byte) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch on result %0d: exp rd=%02h st=%0d txv=%0b txb=%02h, got rd=%02h st=%0d txv=%0b txb=%02h",
                   checked, e.read_data, e.status, e.tx_valid, e.tx_byte,
                   got.read_data, got.status, got.tx_valid, got.tx_byte);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  uart_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  uart_out_t out_data;

  uart_reg_scoreboard sb;
  int unsigned cycle_count;
  int          items_sent;
  bit          sender_fast;
  bit          long_hold_req;

  uart_register_file_loopback_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Beat monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_access(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("testbench failed");
      $finish;
    end
  end

  // Result receiver with random stalls and one long hold-off
  initial begin : receiver
    int stall;
    int results_seen;
    bit recv_fast;
    out_ready = 1'b0;
    results_seen = 0;
    recv_fast = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end
      if (results_seen % 40 == 0) recv_fast = ($urandom_range(0, 3) == 0);
      stall = recv_fast ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      @(negedge clk);
    end
  end

  function automatic uart_in_t make_beat(input logic op, input logic [4:0] idx,
                                         input logic [7:0] d, input logic byte_sz);
    uart_in_t b;
    b.opcode = op;
    b.reg_index = idx;
    b.write_data = d;
    b.access_is_byte = byte_sz;
    return b;
  endfunction

  // Offer one beat after a random gap; returns at the falling edge after acceptance
  task automatic send_beat(input uart_in_t b);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_access(input logic op, input logic [4:0] idx, input logic [7:0] d);
    send_beat(make_beat(op, idx, d, 1'b1));
  endtask

  // Sender goes quiet until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Loopback traffic: enable loopback, push a batch, then pop some back
  task automatic loopback_burst();
    int n;
    int m;
    send_access(OP_WRITE, REG_LCR, 8'($urandom) & 8'h7F);
    send_access(OP_WRITE, REG_MCR, 8'($urandom) | 8'h10);
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) send_access(OP_READ, REG_LSR, 8'($urandom));
      else                           send_access(OP_WRITE, REG_RHR, 8'($urandom));
    end
    if ($urandom_range(0, 5) == 0) send_access(OP_WRITE, REG_IIR, 8'($urandom));
    m = $urandom_range(0, n + 3);
    for (int i = 0; i < m; i++) begin
      if ($urandom_range(0, 7) == 0) send_access(OP_READ, REG_LSR, 8'($urandom));
      else                           send_access(OP_READ, REG_RHR, 8'($urandom));
    end
  endtask

  // Line transmit traffic with loopback off
  task automatic tx_burst();
    int k;
    send_access(OP_WRITE, REG_LCR, 8'($urandom) & 8'h7F);
    send_access(OP_WRITE, REG_MCR, 8'($urandom) & 8'hEF);
    k = $urandom_range(1, 12);
    for (int i = 0; i < k; i++) send_access(OP_WRITE, REG_RHR, 8'($urandom));
  endtask

  // Visit config A, config B or a random LCR setting and poke the low register window
  task automatic bank_walk();
    int k;
    logic [7:0] lcr_val;
    case ($urandom_range(0, 3))
      0:       lcr_val = 8'h80 | 8'($urandom);
      1:       lcr_val = 8'hBF;
      2:       lcr_val = 8'hFF;
      default: lcr_val = 8'($urandom);
    endcase
    send_access(OP_WRITE, REG_LCR, lcr_val);
    k = $urandom_range(4, 12);
    for (int i = 0; i < k; i++)
      send_access(1'($urandom), 5'($urandom_range(0, 8)), 8'($urandom));
    if ($urandom_range(0, 1) == 0) send_access(OP_WRITE, REG_LCR, 8'h00);
  endtask

  task automatic random_accesses(input int k);
    logic [4:0] idx;
    for (int i = 0; i < k; i++) begin
      idx = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 8)) : 5'($urandom);
      send_beat(make_beat(1'($urandom), idx, 8'($urandom), $urandom_range(0, 15) != 0));
    end
  endtask

  initial begin : stimulus
    int random_start;
    int last_drain;
    bit hold_done;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    items_sent = 0;
    sender_fast = 1'b0;
    long_hold_req = 1'b0;
    hold_done = 1'b0;
    cycle_count = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: size error, empty RHR, loopback fill and drain
    send_beat(make_beat(OP_READ, REG_LCR, 8'hFF, 1'b0));
    send_beat(make_beat(OP_WRITE, REG_SCR, 8'h00, 1'b0));
    send_access(OP_READ, REG_RHR, 8'h00);
    send_access(OP_WRITE, REG_MCR, 8'h10);
    send_access(OP_READ, REG_MSR, 8'h00);
    send_access(OP_WRITE, REG_RHR, 8'hFF);
    send_access(OP_WRITE, REG_RHR, 8'h00);
    send_access(OP_READ, REG_LSR, 8'h00);
    send_access(OP_READ, REG_RHR, 8'h00);
    send_access(OP_READ, REG_RHR, 8'h00);
    send_access(OP_READ, REG_RHR, 8'h00);
    // FIFO clear with enable mirrored into IIR
    send_access(OP_WRITE, REG_RHR, 8'h5A);
    send_access(OP_WRITE, REG_IIR, 8'h03);
    send_access(OP_READ, REG_IIR, 8'h00);
    // Config B: EFR enhanced mode, blocked MCR, divisor access
    send_access(OP_WRITE, REG_LCR, 8'hBF);
    send_access(OP_WRITE, REG_IIR, 8'h10);
    send_access(OP_READ, REG_MCR, 8'h00);
    send_access(OP_WRITE, REG_RHR, 8'hAA);
    send_access(OP_WRITE, REG_LCR, 8'h80);
    send_access(OP_READ, REG_RHR, 8'h00);
    // Enhanced IER write sets sleep, which locks the divisor
    send_access(OP_WRITE, REG_LCR, 8'h00);
    send_access(OP_WRITE, REG_IER, 8'hFF);
    send_access(OP_WRITE, REG_MCR, 8'h7F);
    send_access(OP_WRITE, REG_LCR, 8'h80);
    send_access(OP_WRITE, REG_IER, 8'h33);
    send_access(OP_WRITE, REG_LCR, 8'h00);
    // Read-only, unimplemented and undefined offsets, then soft reset and line TX
    send_access(OP_WRITE, REG_MSR, 8'h01);
    send_access(OP_WRITE, REG_UASR, 8'h01);
    send_access(OP_WRITE, REG_WER, 8'h01);
    send_access(OP_READ, REG_SYSC, 8'h00);
    send_access(OP_READ, 5'd31, 8'h00);
    send_access(OP_WRITE, REG_SYSC, 8'h02);
    send_access(OP_WRITE, REG_RHR, 8'hC3);
    drain();

    // Random traffic built mostly from well-formed sequences
    random_start = items_sent;
    last_drain = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      sender_fast = ($urandom_range(0, 4) == 0);
      if (!hold_done && items_sent > random_start + RANDOM_ITEMS / 2) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent - last_drain > 300) begin
        drain();
        last_drain = items_sent;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: loopback_burst();
        4, 5:       tx_burst();
        6:          bank_walk();
        default:    random_accesses($urandom_range(10, 30));
      endcase
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d accesses: %0d line transmits, %0d loopback overruns, %0d soft resets.",
             sb.checked, sb.tx_sent, sb.overruns, sb.soft_resets);
    $display("Status mix ok/size/unimpl/ro/undef/sleep: %0d/%0d/%0d/%0d/%0d/%0d, %0d failures.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.status_seen[5], sb.fail_count);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
